// ----- rtl/tgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and constants of the touch gesture recogniser
// Register indexes, command and swipe codes, queue entry and result word.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CAL_LEFT     = 3'd0,
        REG_CAL_RIGHT    = 3'd1,
        REG_CAL_TOP      = 3'd2,
        REG_CAL_BOTTOM   = 3'd3,
        REG_PRESSURE_MIN = 3'd4,
        REG_PRESSURE_MAX = 3'd5,
        REG_LONG_PRESS   = 3'd6,
        REG_TAP_MAX      = 3'd7
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_SAMPLE  = 1'b0,
        CMD_CONSUME = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        SWIPE_NONE  = 3'd0,
        SWIPE_UP    = 3'd1,
        SWIPE_DOWN  = 3'd2,
        SWIPE_LEFT  = 3'd3,
        SWIPE_RIGHT = 3'd4
    } swipe_t;

    localparam int RAW_W      = 10;
    localparam int POS_W      = 9;
    localparam int DELTA_W    = 10;
    localparam int TIME_W     = 32;
    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 10;

    typedef struct packed {
        logic [9:0]  cal_left;
        logic [9:0]  cal_right;
        logic [9:0]  cal_top;
        logic [9:0]  cal_bottom;
        logic [9:0]  pressure_min;
        logic [9:0]  pressure_max;
        logic [15:0] long_press_ms;
        logic [15:0] tap_max_ms;
    } cfg_t;

    // classified word waiting for the back end
    typedef struct packed {
        cmd_t               cmd;
        logic               contact;
        logic [31:0]        time_ms;
        logic signed [10:0] diff_x;
        logic signed [10:0] den_x;
        logic signed [10:0] diff_y;
        logic signed [10:0] den_y;
    } entry_t;

    typedef struct packed {
        logic               is_down;
        logic               pressed;
        logic               released;
        logic               tap;
        logic               long_press;
        swipe_t             swipe;
        logic               moved;
        logic [8:0]         pos_x;
        logic [8:0]         pos_y;
        logic signed [9:0]  delta_x;
        logic signed [9:0]  delta_y;
        logic [31:0]        last_activity;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tgr_front.sv -----
// ----------------------------------------------------------------------------
// tgr_front: input classifier
// Tests pressure against the contact window and forms the calibration
// operands of both axes for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_front
    import tgr_pkg::*;
(
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire cmd_t        cmd,
    input  wire logic [9:0]  raw_x,
    input  wire logic [9:0]  raw_y,
    input  wire logic [9:0]  pressure,
    input  wire logic [31:0] time_ms,
    input  wire cfg_t        cfg,
    input  wire logic        full,
    output      logic        push,
    output      entry_t      entry
);

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        entry.cmd     = cmd;
        entry.contact = (pressure > cfg.pressure_min) && (pressure < cfg.pressure_max);
        entry.time_ms = time_ms;
        entry.diff_x  = {1'b0, raw_x} - {1'b0, cfg.cal_left};
        entry.den_x   = {1'b0, cfg.cal_right} - {1'b0, cfg.cal_left};
        entry.diff_y  = {1'b0, raw_y} - {1'b0, cfg.cal_top};
        entry.den_y   = {1'b0, cfg.cal_bottom} - {1'b0, cfg.cal_top};
    end

endmodule

`default_nettype wire

// ----- rtl/tgr_fifo.sv -----
// ----------------------------------------------------------------------------
// tgr_fifo: two-word queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_fifo
    import tgr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t wr_data,
    input  wire logic   pop,
    output      entry_t rd_data,
    output      logic   full,
    output      logic   empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && !empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tgr_div.sv -----
// ----------------------------------------------------------------------------
// tgr_div: restoring divider, one quotient bit per cycle
// Unsigned 20-bit dividend by 10-bit divisor; done pulses with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_div
    import tgr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output      logic                  done,
    output      logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  ge;
    logic [DIVISOR_W:0]    rem_sub;

    assign rem_sh   = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tgr_back.sv -----
// ----------------------------------------------------------------------------
// tgr_back: gesture engine
// Pops classified words, scales both axes through two dividers, runs the
// debounce and gesture tracking and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_back
    import tgr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480,
    parameter int DEBOUNCE_MS   = 20,
    parameter int TAP_SLOP      = 12,
    parameter int SWIPE_MIN     = 40
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire entry_t  entry,
    input  wire logic    empty,
    output      logic    pop,
    output      logic    res_valid,
    input  wire logic    res_ready,
    output      result_t res
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    localparam logic [DIVIDEND_W-1:0] SPAN_X   = DIVIDEND_W'(SCREEN_WIDTH);
    localparam logic [DIVIDEND_W-1:0] SPAN_Y   = DIVIDEND_W'(SCREEN_HEIGHT);
    localparam logic [DIVIDEND_W-1:0] LIMIT_X  = DIVIDEND_W'(SCREEN_WIDTH - 1);
    localparam logic [DIVIDEND_W-1:0] LIMIT_Y  = DIVIDEND_W'(SCREEN_HEIGHT - 1);
    localparam logic [31:0]           DEBOUNCE = 32'(DEBOUNCE_MS);
    localparam logic [9:0]            SLOP     = 10'(TAP_SLOP);
    localparam logic [9:0]            SWIPE_TH = 10'(SWIPE_MIN);

    function automatic logic [9:0] abs11(input logic signed [10:0] v);
        logic signed [10:0] n;
        n = -v;
        return v[10] ? n[9:0] : v[9:0];
    endfunction

    function automatic logic [9:0] abs10(input logic signed [9:0] v);
        logic signed [9:0] n;
        n = -v;
        return v[9] ? n : v;
    endfunction

    state_t  state_reg, state_next;
    entry_t  work_reg;
    logic    zero_x_reg, zero_y_reg;
    logic    out_valid_reg;
    result_t res_reg;

    // gesture state
    logic              deb_reg, deb_next;
    logic [31:0]       edge_reg, edge_next;
    logic              long_fired_reg, long_fired_next;
    logic [31:0]       last_act_reg, last_act_next;
    logic              gdown_reg, gdown_next;
    logic [8:0]        start_x_reg, start_x_next;
    logic [8:0]        start_y_reg, start_y_next;
    logic [31:0]       press_time_reg, press_time_next;
    logic              moved_reg, moved_next;
    logic [8:0]        cur_x_reg, cur_x_next;
    logic [8:0]        cur_y_reg, cur_y_next;
    logic signed [9:0] disp_x_reg, disp_x_next;
    logic signed [9:0] disp_y_reg, disp_y_next;

    logic              div_start;
    logic [DIVIDEND_W-1:0] prod_x, prod_y;
    logic [DIVISOR_W-1:0]  dvs_x, dvs_y;
    logic              done_x, done_y;
    logic [DIVIDEND_W-1:0] quo_x, quo_y;
    logic [8:0]        mx, my;
    logic              out_free;
    logic              fire;
    result_t           res_next;

    assign out_free  = !out_valid_reg || res_ready;
    assign fire      = (state_reg == ST_UPDATE) && out_free;
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign div_start = (state_reg == ST_LOAD);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // scale magnitudes; sign and degenerate cases are settled outside the divider
    assign prod_x = DIVIDEND_W'(abs11(work_reg.diff_x)) * SPAN_X;
    assign prod_y = DIVIDEND_W'(abs11(work_reg.diff_y)) * SPAN_Y;
    assign dvs_x  = abs11(work_reg.den_x);
    assign dvs_y  = abs11(work_reg.den_y);

    tgr_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_x),
        .divisor  (dvs_x),
        .done     (done_x),
        .quotient (quo_x)
    );

    tgr_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_y),
        .divisor  (dvs_y),
        .done     (done_y),
        .quotient (quo_y)
    );

    // clamp to the screen
    assign mx = zero_x_reg ? 9'd0 : ((quo_x > LIMIT_X) ? LIMIT_X[8:0] : quo_x[8:0]);
    assign my = zero_y_reg ? 9'd0 : ((quo_y > LIMIT_Y) ? LIMIT_Y[8:0] : quo_y[8:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = (entry.cmd == CMD_CONSUME) ? ST_UPDATE : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (done_x && done_y)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic              skip;
        logic [31:0]       ms;
        logic [8:0]        base_x, base_y;
        logic [31:0]       press_base;
        logic              moved_new;
        logic              long_base;
        logic signed [9:0] dx, dy;
        logic [9:0]        ax, ay;

        deb_next        = deb_reg;
        edge_next       = edge_reg;
        long_fired_next = long_fired_reg;
        last_act_next   = last_act_reg;
        gdown_next      = gdown_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        press_time_next = press_time_reg;
        moved_next      = moved_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        disp_x_next     = disp_x_reg;
        disp_y_next     = disp_y_reg;

        skip       = 1'b0;
        ms         = work_reg.time_ms;
        base_x     = start_x_reg;
        base_y     = start_y_reg;
        press_base = press_time_reg;
        moved_new  = moved_reg;
        long_base  = long_fired_reg;
        dx         = '0;
        dy         = '0;
        ax         = abs10(disp_x_reg);
        ay         = abs10(disp_y_reg);

        res_next            = '0;
        res_next.swipe      = SWIPE_NONE;

        if (fire)
        begin
            if (work_reg.cmd == CMD_CONSUME)
            begin
                long_fired_next = 1'b1;
            end
            else
            begin
                if (work_reg.contact != deb_reg)
                begin
                    if ((ms - edge_reg) >= DEBOUNCE)
                    begin
                        deb_next  = work_reg.contact;
                        edge_next = ms;
                    end
                    else if (!work_reg.contact)
                    begin
                        // bounce toward release: ignore the word, hold the gesture state
                        skip = 1'b1;
                    end
                end
                else
                begin
                    edge_next = ms;
                end

                if (!skip)
                begin
                    if (deb_next)
                    begin
                        last_act_next = ms;
                        if (!gdown_reg)
                        begin
                            gdown_next       = 1'b1;
                            res_next.pressed = 1'b1;
                            start_x_next     = mx;
                            start_y_next     = my;
                            press_time_next  = ms;
                            base_x           = mx;
                            base_y           = my;
                            press_base       = ms;
                            moved_new        = 1'b0;
                            long_base        = 1'b0;
                        end
                        cur_x_next  = mx;
                        cur_y_next  = my;
                        dx          = {1'b0, mx} - {1'b0, base_x};
                        dy          = {1'b0, my} - {1'b0, base_y};
                        disp_x_next = dx;
                        disp_y_next = dy;
                        if ((abs10(dx) > SLOP) || (abs10(dy) > SLOP))
                        begin
                            moved_new = 1'b1;
                        end
                        moved_next      = moved_new;
                        long_fired_next = long_base;
                        if (!long_base && !moved_new &&
                            ((ms - press_base) >= {16'd0, cfg.long_press_ms}))
                        begin
                            res_next.long_press = 1'b1;
                            long_fired_next     = 1'b1;
                        end
                    end
                    else if (gdown_reg)
                    begin
                        gdown_next        = 1'b0;
                        res_next.released = 1'b1;
                        last_act_next     = ms;
                        if (!moved_reg && !long_fired_reg &&
                            ((ms - press_time_reg) <= {16'd0, cfg.tap_max_ms}))
                        begin
                            res_next.tap = 1'b1;
                        end
                        else if ((ax >= SWIPE_TH) || (ay >= SWIPE_TH))
                        begin
                            if (ax > ay)
                            begin
                                res_next.swipe = (disp_x_reg > 10'sd0) ? SWIPE_RIGHT
                                                                       : SWIPE_LEFT;
                            end
                            else
                            begin
                                res_next.swipe = (disp_y_reg > 10'sd0) ? SWIPE_DOWN
                                                                       : SWIPE_UP;
                            end
                        end
                    end
                end
            end
        end

        res_next.is_down       = gdown_next;
        res_next.moved         = moved_next;
        res_next.pos_x         = cur_x_next;
        res_next.pos_y         = cur_y_next;
        res_next.delta_x       = disp_x_next;
        res_next.delta_y       = disp_y_next;
        res_next.last_activity = last_act_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= entry;
        end
        if (state_reg == ST_LOAD)
        begin
            zero_x_reg <= (work_reg.den_x == '0) || (work_reg.diff_x == '0) ||
                          (work_reg.diff_x[10] != work_reg.den_x[10]);
            zero_y_reg <= (work_reg.den_y == '0) || (work_reg.diff_y == '0) ||
                          (work_reg.diff_y[10] != work_reg.den_y[10]);
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            deb_reg        <= 1'b0;
            edge_reg       <= '0;
            long_fired_reg <= 1'b0;
            last_act_reg   <= '0;
            gdown_reg      <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            press_time_reg <= '0;
            moved_reg      <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            disp_x_reg     <= '0;
            disp_y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            deb_reg        <= deb_next;
            edge_reg       <= edge_next;
            long_fired_reg <= long_fired_next;
            last_act_reg   <= last_act_next;
            gdown_reg      <= gdown_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            press_time_reg <= press_time_next;
            moved_reg      <= moved_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            disp_x_reg     <= disp_x_next;
            disp_y_reg     <= disp_y_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/touch_gesture_recognizer.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_recognizer: resistive touch panel gesture recogniser
//
// Words in on the s_axis channel: tuser is the command (sample or consume),
// tdata carries one panel sample and its millisecond timestamp. One word out
// on the m_axis channel for every word in, in order: contact state, the
// pressed / released / tap / long press / swipe events, calibrated position,
// displacement from the press start and the last activity time.
// A sample word goes from the queue through the load, division and update
// states to a valid output word; a consume word goes straight to update. The
// 20-step restoring division scales each axis (one divider per axis, run side
// by side), and the engine finishes one word before it pops the next.
// A two-word queue sits behind the input: up to two further words are taken
// while one is being worked on. When m_axis_tready is low the finished word
// holds in the output register and the engine waits, then the queue fills
// and s_axis_tready drops.
// Reset clears the gesture state, the queue and the output valid flag, and
// loads the calibration and timing registers with their defaults.
// cfg_we writes cfg_wdata to register cfg_addr at once; the user must use it
// only while no word is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_recognizer
    import tgr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480,
    parameter int DEBOUNCE_MS   = 20,
    parameter int TAP_SLOP      = 12,
    parameter int SWIPE_MIN     = 40
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // raw_x[9:0], raw_y[19:10], pressure[29:20], time_ms[61:30], zero pad[63:62]
    input  wire logic [63:0] s_axis_tdata,
    // cmd[0]
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // is_down[0], pressed[1], released[2], tap[3], long_press[4], swipe[7:5],
    // moved[8], pos_x[17:9], pos_y[26:18], delta_x[36:27], delta_y[46:37],
    // last_activity[78:47], zero pad[79]
    output      logic [79:0] m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    cfg_t       cfg_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    entry_t     push_entry;
    entry_t     head_entry;
    result_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_left      <= 10'd0;
            cfg_reg.cal_right     <= 10'd1023;
            cfg_reg.cal_top       <= 10'd0;
            cfg_reg.cal_bottom    <= 10'd1023;
            cfg_reg.pressure_min  <= 10'd10;
            cfg_reg.pressure_max  <= 10'd1000;
            cfg_reg.long_press_ms <= 16'd600;
            cfg_reg.tap_max_ms    <= 16'd250;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CAL_LEFT:     cfg_reg.cal_left      <= cfg_wdata[9:0];
                REG_CAL_RIGHT:    cfg_reg.cal_right     <= cfg_wdata[9:0];
                REG_CAL_TOP:      cfg_reg.cal_top       <= cfg_wdata[9:0];
                REG_CAL_BOTTOM:   cfg_reg.cal_bottom    <= cfg_wdata[9:0];
                REG_PRESSURE_MIN: cfg_reg.pressure_min  <= cfg_wdata[9:0];
                REG_PRESSURE_MAX: cfg_reg.pressure_max  <= cfg_wdata[9:0];
                REG_LONG_PRESS:   cfg_reg.long_press_ms <= cfg_wdata;
                REG_TAP_MAX:      cfg_reg.tap_max_ms    <= cfg_wdata;
                default:          cfg_reg               <= cfg_reg;
            endcase
        end
    end

    tgr_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd_t'(s_axis_tuser)),
        .raw_x    (s_axis_tdata[9:0]),
        .raw_y    (s_axis_tdata[19:10]),
        .pressure (s_axis_tdata[29:20]),
        .time_ms  (s_axis_tdata[61:30]),
        .cfg      (cfg_reg),
        .full     (q_full),
        .push     (q_push),
        .entry    (push_entry)
    );

    tgr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_entry),
        .pop     (q_pop),
        .rd_data (head_entry),
        .full    (q_full),
        .empty   (q_empty)
    );

    tgr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .DEBOUNCE_MS   (DEBOUNCE_MS),
        .TAP_SLOP      (TAP_SLOP),
        .SWIPE_MIN     (SWIPE_MIN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .entry     (head_entry),
        .empty     (q_empty),
        .pop       (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {1'b0, res.last_activity, res.delta_y, res.delta_x,
                           res.pos_y, res.pos_x, res.moved, res.swipe,
                           res.long_press, res.tap, res.released, res.pressed,
                           res.is_down};

    // a tap is a release of an unmoved press
    a_tap_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.tap |-> res.released && !res.moved)
        else $error("tap without an unmoved release");

    // a swipe is reported only on a release that was not a tap
    a_swipe_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.swipe != SWIPE_NONE) |-> res.released && !res.tap)
        else $error("swipe outside a non-tap release");

    a_long_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.long_press |-> res.is_down && !res.moved)
        else $error("long press while released or moved");

    // the press start point is the current point
    a_press_origin: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.pressed |->
            res.is_down && (res.delta_x == '0) && (res.delta_y == '0))
        else $error("press with nonzero displacement");

endmodule

`default_nettype wire

// ----- dv/touch_gesture_recognizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_tb: self-checking bench for the gesture recogniser
// Drives panel samples and consume words in bursts, stalls the result side on
// a pattern of its own, and checks every result word field by field against
// a behavioural model of the recogniser or a written expectation. Runs a
// directed table at the reset configuration, then randomised press / hold /
// swipe / bounce sequences under several register settings, extremes included.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_tb;
    import tgr_pkg::*;

    localparam int SCREEN_W         = 320;
    localparam int SCREEN_H         = 480;
    localparam int DEBOUNCE         = 20;
    localparam int SLOP             = 12;
    localparam int SWIPE_DIST       = 40;
    localparam int SETTLE_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AT     = 260;

    typedef struct {
        cmd_t        cmd;
        logic [9:0]  raw_x;
        logic [9:0]  raw_y;
        logic [9:0]  pressure;
        logic [31:0] ms;
        bit          typed;
        result_t     want;
    } panel_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    touch_gesture_recognizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // model copy of the registers and the gesture state
    cfg_t        cfg_model;
    bit          st_contact, st_long_done, st_down, st_moved;
    bit [31:0]   st_edge_ms, st_activity_ms, st_press_ms;
    int          st_start_x, st_start_y, st_cur_x, st_cur_y, st_disp_x, st_disp_y;

    panel_word_t panel_q[$];
    panel_word_t dir_rows[$];
    result_t     gesture_fifo[$];
    panel_word_t cur_word;
    bit [31:0]   tb_ms;
    int          n_errors = 0;
    int          results_seen = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          seg_mode = 0;
    int          seg_left = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;
    int          quiet_cycles = 0;

    function automatic void reset_model();
        cfg_model.cal_left      = 10'd0;
        cfg_model.cal_right     = 10'd1023;
        cfg_model.cal_top       = 10'd0;
        cfg_model.cal_bottom    = 10'd1023;
        cfg_model.pressure_min  = 10'd10;
        cfg_model.pressure_max  = 10'd1000;
        cfg_model.long_press_ms = 16'd600;
        cfg_model.tap_max_ms    = 16'd250;
        st_contact = 1'b0;
        st_long_done = 1'b0;
        st_down = 1'b0;
        st_moved = 1'b0;
        st_edge_ms = '0;
        st_activity_ms = '0;
        st_press_ms = '0;
        st_start_x = 0;
        st_start_y = 0;
        st_cur_x = 0;
        st_cur_y = 0;
        st_disp_x = 0;
        st_disp_y = 0;
    endfunction

    // linear map with truncating division, clamped to the screen
    function automatic int scale_axis(int v, int lo, int hi, int span);
        int c;
        if (lo == hi)
            return 0;
        c = ((v - lo) * span) / (hi - lo);
        if (c < 0)
            c = 0;
        if (c > span - 1)
            c = span - 1;
        return c;
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic result_t recognise_gesture(panel_word_t w);
        result_t   r;
        bit        contact, skip;
        int        mx, my, ax, ay;
        bit [31:0] dt, held_ms;
        r = '0;
        skip = 1'b0;
        mx = 0;
        my = 0;
        if (w.cmd == CMD_CONSUME)
            st_long_done = 1'b1;
        else
        begin
            contact = (w.pressure > cfg_model.pressure_min) &&
                      (w.pressure < cfg_model.pressure_max);
            if (contact)
            begin
                mx = scale_axis(w.raw_x, cfg_model.cal_left, cfg_model.cal_right, SCREEN_W);
                my = scale_axis(w.raw_y, cfg_model.cal_top, cfg_model.cal_bottom, SCREEN_H);
            end
            dt = w.ms - st_edge_ms;
            if (contact != st_contact)
            begin
                if (dt >= 32'(DEBOUNCE))
                begin
                    st_contact = contact;
                    st_edge_ms = w.ms;
                end
                else if (!contact)
                    skip = 1'b1;    // ignore a bounce towards release
            end
            else
                st_edge_ms = w.ms;

            if (!skip)
            begin
                if (st_contact)
                begin
                    st_activity_ms = w.ms;
                    if (!st_down)
                    begin
                        st_down = 1'b1;
                        r.pressed = 1'b1;
                        st_start_x = mx;
                        st_start_y = my;
                        st_press_ms = w.ms;
                        st_moved = 1'b0;
                        st_long_done = 1'b0;
                    end
                    st_cur_x = mx;
                    st_cur_y = my;
                    st_disp_x = mx - st_start_x;
                    st_disp_y = my - st_start_y;
                    if (magnitude(st_disp_x) > SLOP || magnitude(st_disp_y) > SLOP)
                        st_moved = 1'b1;
                    held_ms = w.ms - st_press_ms;
                    if (!st_long_done && !st_moved &&
                        held_ms >= {16'd0, cfg_model.long_press_ms})
                    begin
                        r.long_press = 1'b1;
                        st_long_done = 1'b1;
                    end
                end
                else if (st_down)
                begin
                    ax = magnitude(st_disp_x);
                    ay = magnitude(st_disp_y);
                    st_down = 1'b0;
                    r.released = 1'b1;
                    st_activity_ms = w.ms;
                    held_ms = w.ms - st_press_ms;
                    if (!st_moved && held_ms <= {16'd0, cfg_model.tap_max_ms} && !st_long_done)
                        r.tap = 1'b1;
                    else if (ax >= SWIPE_DIST || ay >= SWIPE_DIST)
                    begin
                        if (ax > ay)
                            r.swipe = (st_disp_x > 0) ? SWIPE_RIGHT : SWIPE_LEFT;
                        else
                            r.swipe = (st_disp_y > 0) ? SWIPE_DOWN : SWIPE_UP;
                    end
                end
            end
        end
        r.is_down = st_down;
        r.moved = st_moved;
        r.pos_x = st_cur_x[8:0];
        r.pos_y = st_cur_y[8:0];
        r.delta_x = st_disp_x[9:0];
        r.delta_y = st_disp_y[9:0];
        r.last_activity = st_activity_ms;
        return r;
    endfunction

    function automatic result_t mk_gesture(bit dn, bit pr, bit rl, bit tp, bit lp, swipe_t sw,
                                           bit mv, int x, int y, int dx, int dy, int act);
        result_t r;
        r.is_down = dn;
        r.pressed = pr;
        r.released = rl;
        r.tap = tp;
        r.long_press = lp;
        r.swipe = sw;
        r.moved = mv;
        r.pos_x = x[8:0];
        r.pos_y = y[8:0];
        r.delta_x = dx[9:0];
        r.delta_y = dy[9:0];
        r.last_activity = act;
        return r;
    endfunction

    function automatic string fmt_gesture(result_t r);
        return $sformatf("dn=%0b prs=%0b rel=%0b tap=%0b lp=%0b sw=%0d mv=%0b x=%0d y=%0d dx=%0d dy=%0d act=%0d",
                         r.is_down, r.pressed, r.released, r.tap, r.long_press, r.swipe,
                         r.moved, r.pos_x, r.pos_y, r.delta_x, r.delta_y, r.last_activity);
    endfunction

    function automatic logic [9:0] clip_raw(int v);
        if (v < 0)
            return 10'd0;
        if (v > 1023)
            return 10'd1023;
        return v[9:0];
    endfunction

    function automatic panel_word_t row(cmd_t c, int x, int y, int pr, bit [31:0] ms,
                                        bit typed, result_t want);
        panel_word_t w;
        w.cmd = c;
        w.raw_x = clip_raw(x);
        w.raw_y = clip_raw(y);
        w.pressure = clip_raw(pr);
        w.ms = ms;
        w.typed = typed;
        w.want = want;
        return w;
    endfunction

    function automatic logic [9:0] contact_pr();
        if (int'(cfg_model.pressure_max) > int'(cfg_model.pressure_min) + 1)
            return 10'($urandom_range(cfg_model.pressure_min + 1, cfg_model.pressure_max - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [9:0] release_pr();
        if ($urandom_range(0, 1))
            return 10'($urandom_range(0, cfg_model.pressure_min));
        return 10'($urandom_range(cfg_model.pressure_max, 1023));
    endfunction

    task automatic add_word(cmd_t c, int x, int y, logic [9:0] pr);
        panel_q.push_back(row(c, x, y, pr, tb_ms, 1'b0, '0));
    endtask

    // one press / hold / move / release sequence, or a short run of noise
    task automatic make_gesture();
        int kind, x, y, n, i, dir, span;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    tb_ms = $urandom;
                else
                    tb_ms += $urandom_range(0, 100);
                add_word(cmd_t'($urandom_range(0, 1)), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), 10'($urandom_range(0, 1023)));
            end
        end
        else
        begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
            dir = $urandom_range(0, 3);
            tb_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : $urandom_range(20, 400);
            add_word(CMD_SAMPLE, x, y, contact_pr());
            case (kind)
                1, 2, 3: n = $urandom_range(0, 3);
                4, 5:    n = $urandom_range(2, 6);
                6, 7, 8: n = $urandom_range(1, 5);
                default: n = $urandom_range(0, 8);
            endcase
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 11))
                    0:
                    begin
                        tb_ms += $urandom_range(1, 30);
                        add_word(CMD_CONSUME, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 10'($urandom_range(0, 1023)));
                    end
                    1:
                    begin
                        tb_ms += $urandom_range(1, 19);
                        add_word(CMD_SAMPLE, x, y, release_pr());
                    end
                    default:
                    begin
                        if (kind == 4 || kind == 5)
                            tb_ms += cfg_model.long_press_ms / 3 + $urandom_range(1, 60);
                        else
                            tb_ms += $urandom_range(1, 80);
                        if (kind >= 6 && kind <= 8)
                        begin
                            span = $urandom_range(30, 200);
                            case (dir)
                                0: x = clip_raw(x + span);
                                1: x = clip_raw(x - span);
                                2: y = clip_raw(y + span);
                                default: y = clip_raw(y - span);
                            endcase
                        end
                        else
                        begin
                            span = (kind == 9) ? 300 : 25;
                            x = clip_raw(x + $urandom_range(0, 2 * span) - span);
                            y = clip_raw(y + $urandom_range(0, 2 * span) - span);
                        end
                        add_word(CMD_SAMPLE, x, y, contact_pr());
                    end
                endcase
            end
            if ($urandom_range(0, 4) == 0)
            begin
                tb_ms += $urandom_range(1, 19);
                add_word(CMD_SAMPLE, x, y, release_pr());
            end
            tb_ms += (kind <= 3) ? $urandom_range(1, 150) : $urandom_range(20, 200);
            add_word(CMD_SAMPLE, x, y, release_pr());
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (panel_q.size() != 0 || s_axis_tvalid || gesture_fifo.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write every register, then run a batch of random gestures to completion
    task automatic run_phase(cfg_t c, int n_words);
        logic [15:0] vals [8];
        int          i;
        vals[REG_CAL_LEFT]     = {6'($urandom), c.cal_left};
        vals[REG_CAL_RIGHT]    = {6'($urandom), c.cal_right};
        vals[REG_CAL_TOP]      = {6'($urandom), c.cal_top};
        vals[REG_CAL_BOTTOM]   = {6'($urandom), c.cal_bottom};
        vals[REG_PRESSURE_MIN] = {6'($urandom), c.pressure_min};
        vals[REG_PRESSURE_MAX] = {6'($urandom), c.pressure_max};
        vals[REG_LONG_PRESS]   = c.long_press_ms;
        vals[REG_TAP_MAX]      = c.tap_max_ms;
        for (i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_addr <= reg_idx_t'(i);
            cfg_wdata <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_model = c;
        while (panel_q.size() < n_words)
            make_gesture();
        wait_idle();
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge clk)
    begin : drive_words
        bit      offer;
        result_t predicted;
        offer = s_axis_tvalid;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = recognise_gesture(cur_word);
                gesture_fifo.push_back(cur_word.typed ? cur_word.want : predicted);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (panel_q.size() > 0)
                begin
                    cur_word = panel_q.pop_front();
                    s_axis_tdata <= {2'b00, cur_word.ms, cur_word.pressure,
                                     cur_word.raw_y, cur_word.raw_x};
                    s_axis_tuser <= cur_word.cmd;
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // receiver: check each result word, then pick the next ready level
    always @(posedge clk)
    begin : take_results
        result_t got, want;
        string   bad;
        bit      rdy;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got.is_down = m_axis_tdata[0];
                got.pressed = m_axis_tdata[1];
                got.released = m_axis_tdata[2];
                got.tap = m_axis_tdata[3];
                got.long_press = m_axis_tdata[4];
                got.swipe = swipe_t'(m_axis_tdata[7:5]);
                got.moved = m_axis_tdata[8];
                got.pos_x = m_axis_tdata[17:9];
                got.pos_y = m_axis_tdata[26:18];
                got.delta_x = m_axis_tdata[36:27];
                got.delta_y = m_axis_tdata[46:37];
                got.last_activity = m_axis_tdata[78:47];
                if (gesture_fifo.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result word %0d: %s", results_seen, fmt_gesture(got));
                end
                else
                begin
                    want = gesture_fifo.pop_front();
                    bad = "";
                    if (got.is_down !== want.is_down)
                        bad = {bad, " is_down"};
                    if (got.pressed !== want.pressed)
                        bad = {bad, " pressed"};
                    if (got.released !== want.released)
                        bad = {bad, " released"};
                    if (got.tap !== want.tap)
                        bad = {bad, " tap"};
                    if (got.long_press !== want.long_press)
                        bad = {bad, " long_press"};
                    if (got.swipe !== want.swipe)
                        bad = {bad, " swipe"};
                    if (got.moved !== want.moved)
                        bad = {bad, " moved"};
                    if (got.pos_x !== want.pos_x)
                        bad = {bad, " pos_x"};
                    if (got.pos_y !== want.pos_y)
                        bad = {bad, " pos_y"};
                    if (got.delta_x !== want.delta_x)
                        bad = {bad, " delta_x"};
                    if (got.delta_y !== want.delta_y)
                        bad = {bad, " delta_y"};
                    if (got.last_activity !== want.last_activity)
                        bad = {bad, " last_activity"};
                    if (bad != "")
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result word %0d mismatch in%s\n  expected %s\n  actual   %s",
                                     results_seen, bad, fmt_gesture(want), fmt_gesture(got));
                    end
                end
            end

            // one long hold-off so the input queue fills and back-pressures
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                rdy = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(5, 60);
                end
                else
                    seg_left--;
                case (seg_mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : run
        cfg_t    c;
        result_t none;
        int      p;
        none = '0;
        reset_model();
        tb_ms = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: cal 0..1023, pressure 10..1000, long 600, tap 250
        dir_rows.push_back(row(CMD_SAMPLE, 1023, 0, 0, 100, 1'b1, none));
        dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 500, 200, 1'b1,
            mk_gesture(1, 1, 0, 0, 0, SWIPE_NONE, 0, 0, 0, 0, 0, 200)));
        dir_rows.push_back(row(CMD_SAMPLE, 1023, 1023, 500, 210, 1'b1,
            mk_gesture(1, 0, 0, 0, 0, SWIPE_NONE, 1, 319, 479, 319, 479, 210)));
        // bounce towards release: ignored, state held
        dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 0, 215, 1'b1,
            mk_gesture(1, 0, 0, 0, 0, SWIPE_NONE, 1, 319, 479, 319, 479, 210)));
        dir_rows.push_back(row(CMD_SAMPLE, 0, 0, 0, 240, 1'b1,
            mk_gesture(0, 0, 1, 0, 0, SWIPE_DOWN, 1, 319, 479, 319, 479, 240)));
        dir_rows.push_back(row(CMD_CONSUME, 1023, 1023, 1023, 241, 1'b1,
            mk_gesture(0, 0, 0, 0, 0, SWIPE_NONE, 1, 319, 479, 319, 479, 240)));
        // tap just inside the pressure window
        dir_rows.push_back(row(CMD_SAMPLE, 512, 512, 11, 300, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 515, 510, 999, 350, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 515, 510, 1000, 400, 1'b0, none));
        // bounce towards press, then full-scale pressure
        dir_rows.push_back(row(CMD_SAMPLE, 600, 600, 500, 405, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 600, 600, 1023, 430, 1'b0, none));
        // long press exactly at the threshold, no tap on release
        dir_rows.push_back(row(CMD_SAMPLE, 600, 600, 500, 500, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 600, 600, 500, 1100, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 600, 600, 10, 1300, 1'b0, none));
        // swipes left, up, right
        dir_rows.push_back(row(CMD_SAMPLE, 800, 500, 500, 1400, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 300, 520, 500, 1450, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 300, 520, 0, 1500, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 500, 900, 500, 1600, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 500, 200, 500, 1650, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 500, 200, 0, 1700, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 100, 500, 500, 1800, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 900, 500, 500, 1850, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 900, 500, 0, 1900, 1'b0, none));
        // consume blocks the long press across a timestamp wrap
        dir_rows.push_back(row(CMD_SAMPLE, 500, 500, 500, 32'hFFFF_FFF0, 1'b0, none));
        dir_rows.push_back(row(CMD_CONSUME, 0, 0, 0, 32'hFFFF_FFF8, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 500, 500, 500, 32'h0000_0300, 1'b0, none));
        dir_rows.push_back(row(CMD_SAMPLE, 500, 500, 0, 32'h0000_0400, 1'b0, none));
        foreach (dir_rows[i])
            panel_q.push_back(dir_rows[i]);
        wait_idle();

        // reversed calibration, widest pressure window, zero times
        c.cal_left = 10'd1023;
        c.cal_right = 10'd0;
        c.cal_top = 10'd1023;
        c.cal_bottom = 10'd0;
        c.pressure_min = 10'd0;
        c.pressure_max = 10'd1023;
        c.long_press_ms = 16'd0;
        c.tap_max_ms = 16'd0;
        run_phase(c, 100);

        // equal calibration ends on both axes, longest times
        c.cal_left = 10'($urandom_range(0, 1023));
        c.cal_right = c.cal_left;
        c.cal_top = 10'($urandom_range(0, 1023));
        c.cal_bottom = c.cal_top;
        c.long_press_ms = 16'hFFFF;
        c.tap_max_ms = 16'hFFFF;
        run_phase(c, 80);

        // empty pressure window: contact never seen
        c.pressure_min = 10'd1023;
        c.pressure_max = 10'd0;
        run_phase(c, 20);

        for (p = 0; p < 4; p++)
        begin
            c.cal_left = 10'($urandom_range(0, 300));
            c.cal_right = 10'($urandom_range(700, 1023));
            c.cal_top = 10'($urandom_range(700, 1023));
            c.cal_bottom = 10'($urandom_range(0, 300));
            c.pressure_min = 10'($urandom_range(0, 100));
            c.pressure_max = 10'($urandom_range(800, 1023));
            c.long_press_ms = 16'($urandom_range(50, 2000));
            c.tap_max_ms = 16'($urandom_range(30, 500));
            run_phase(c, 150);
        end

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
